// ===== design/apu_pkg.sv =====
`timescale 1ns / 1ps

package apu_pkg;

  localparam int PARAM_COUNT = 4096;
  localparam int MEM_AW      = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;
  localparam int MEM_W       = 80;   // {first moment 32, second moment 48}

  localparam int IDX_W     = 12;
  localparam int VAL_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int ITER_W    = 6;

  localparam logic [CFG_IDX_W-1:0] REG_BASE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EPS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B1    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_B2    = 3'd4;

  localparam logic [31:0] BASE_RESET = 32'd4294967;
  localparam logic [31:0] EPS_RESET  = 32'd429;
  localparam logic [31:0] B1_RESET   = 32'd3865470566;
  localparam logic [31:0] B2_RESET   = 32'd4290672329;

  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
  localparam logic [39:0] CAP40   = 40'hFF_FFFF_FFFF;
  localparam logic [47:0] CAP48   = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic              start;
    logic              sqrt_mode;
    logic [ITER_W-1:0] iters;
  } ds_ctl_t;

  typedef struct packed {
    logic done;
    logic sat;
  } ds_stat_t;

endpackage

// ===== design/apu_if.sv =====
`timescale 1ns / 1ps

interface apu_in_if import apu_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        param_index;
  logic signed [VAL_W-1:0] gradient;
  logic signed [VAL_W-1:0] param_value;
  logic                    step_end;

  modport source (output valid, param_index, gradient, param_value, step_end, input ready);
  modport sink   (input valid, param_index, gradient, param_value, step_end, output ready);
endinterface

interface apu_out_if import apu_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        out_index;
  logic signed [VAL_W-1:0] new_value;

  modport source (output valid, out_index, new_value, input ready);
  modport sink   (input valid, out_index, new_value, output ready);
endinterface

interface apu_cfg_if import apu_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/adam_parameter_update_top.sv =====
`timescale 1ns / 1ps

// Adam parameter update, one parameter per item, fixed point (Q8.24 values).
// in_ch: index, gradient, current value, step_end flag. out_ch: index and
// updated value, one result per item, in order. cfg_ch: register writes
// (0 base rate, 1 decay, 2 epsilon, 3 beta1, 4 beta2); other indexes ignored.
// An item runs through the sequencer states from input transfer to its result
// on out_ch, using one shared multiplier and one bit-serial divide/root unit
// (three divisions of 40/48/40 bits and a 32-step root). in_ch is not ready
// during that time, so items are taken one at a time. An item with step_end
// then has the decayed rate recomputed before the next item is taken; a write
// to base rate or decay while idle does the same. The next item can be taken
// while a result still waits on out_ch; a stalled receiver holds that result
// and stops the next one at its final stage. After reset a clearing pass zeroes
// all PARAM_COUNT (4096) entries of the moment memory, taking cfg_ch meanwhile.
module adam_parameter_update_top import apu_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  apu_in_if.sink    in_ch,
  apu_out_if.source out_ch,
  apu_cfg_if.sink   cfg_ch
);

  localparam logic [4:0] ST_CLEAR = 5'd0;
  localparam logic [4:0] ST_IDLE  = 5'd1;
  localparam logic [4:0] ST_MOM   = 5'd2;
  localparam logic [4:0] ST_GSQ   = 5'd3;
  localparam logic [4:0] ST_VH    = 5'd4;
  localparam logic [4:0] ST_VL    = 5'd5;
  localparam logic [4:0] ST_GH    = 5'd6;
  localparam logic [4:0] ST_GL    = 5'd7;
  localparam logic [4:0] ST_P1    = 5'd8;
  localparam logic [4:0] ST_P2    = 5'd9;
  localparam logic [4:0] ST_DMH   = 5'd10;
  localparam logic [4:0] ST_WMH   = 5'd11;
  localparam logic [4:0] ST_WVH   = 5'd12;
  localparam logic [4:0] ST_WSQ   = 5'd13;
  localparam logic [4:0] ST_WR    = 5'd14;
  localparam logic [4:0] ST_DL    = 5'd15;
  localparam logic [4:0] ST_DS    = 5'd16;
  localparam logic [4:0] ST_WB    = 5'd17;
  localparam logic [4:0] ST_R1    = 5'd18;
  localparam logic [4:0] ST_R2    = 5'd19;
  localparam logic [4:0] ST_R3    = 5'd20;

  logic [4:0] state_r, state_nxt;
  logic [MEM_AW-1:0] clr_addr_r;

  // configuration and step state
  logic [31:0] base_r, decay_r, eps_r, b1_r, b2_r;
  logic [31:0] step_r, rate_r;
  logic [32:0] bfp_r, bsp_r;

  // item payload
  logic [IDX_W-1:0]        idx_r;
  logic signed [VAL_W-1:0] g_r, p_r;
  logic                    last_r, stored_r;
  logic signed [31:0]      mn_r;
  logic [46:0]             g2_r;
  logic [49:0]             acc_r;
  logic [47:0]             vn_r;
  logic [32:0]             p1_r, p2_r;
  logic [39:0]             mh_r, r_r;
  logic signed [31:0]      nv_r;

  logic                    out_valid_r;
  logic [IDX_W-1:0]        out_index_r;
  logic signed [VAL_W-1:0] new_value_r;

  logic in_xfer, cfg_xfer, out_free, out_load, stored_in;

  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod_r;

  ds_ctl_t     ds_ctl;
  ds_stat_t    ds_stat;
  logic [63:0] ds_hi, ds_lo, ds_dsr;
  logic [47:0] ds_q;

  logic              mem_we;
  logic [MEM_AW-1:0] mem_waddr;
  logic [MEM_W-1:0]  mem_wdata, mem_rdata;

  logic signed [31:0] m_old;
  logic [47:0]        v_old;
  logic signed [32:0] g_ext, g_abs;
  logic [31:0]        ag;
  logic [32:0]        cb2, c1, c2;
  logic signed [67:0] mom_sum;
  logic [49:0]        acc_sum;
  logic signed [32:0] mn_ext, mn_abs;
  logic [31:0]        mag;
  logic [47:0]        vh_w;
  logic [32:0]        den_w;
  logic [39:0]        r_w;
  logic signed [51:0] nv_full;
  logic signed [31:0] nv_sat;

  assign in_xfer   = in_ch.valid & in_ch.ready;
  assign cfg_xfer  = cfg_ch.valid & cfg_ch.ready;
  assign out_free  = ~out_valid_r | out_ch.ready;
  assign out_load  = (state_r == ST_WB) & out_free;
  assign stored_in = 32'(in_ch.param_index) < 32'(PARAM_COUNT);

  assign cfg_ch.ready = (state_r == ST_IDLE) | (state_r == ST_CLEAR);
  assign in_ch.ready  = (state_r == ST_IDLE) & ~cfg_ch.valid;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_index = out_index_r;
  assign out_ch.new_value = new_value_r;

  apu_mult u_mult (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  apu_divsqrt u_divsqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ds_ctl),
    .hi    (ds_hi),
    .lo    (ds_lo),
    .dsr   (ds_dsr),
    .stat  (ds_stat),
    .q_r   (ds_q)
  );

  apu_mem u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (in_xfer),
    .raddr   (MEM_AW'(in_ch.param_index)),
    .rdata_r (mem_rdata)
  );

  // ---------------- datapath helpers ----------------
  always_comb begin
    m_old   = stored_r ? $signed(mem_rdata[79:48]) : 32'sd0;
    v_old   = stored_r ? mem_rdata[47:0] : 48'd0;
    g_ext   = 33'(g_r);
    g_abs   = g_ext[32] ? -g_ext : g_ext;
    ag      = g_abs[31:0];
    cb2     = ONE_Q32 - {1'b0, b2_r};
    c1      = ONE_Q32 - p1_r;
    c2      = ONE_Q32 - p2_r;
    // m*b1 + g*(1-b1) = (m-g)*b1 + g*2^32
    mom_sum = prod_r + $signed({{4{g_r[31]}}, g_r, 32'b0});
    acc_sum = acc_r + 50'(prod_r[67:32]);
    mn_ext  = 33'(mn_r);
    mn_abs  = mn_ext[32] ? -mn_ext : mn_ext;
    mag     = mn_abs[31:0];
    vh_w    = ds_stat.sat ? CAP48 : ds_q;
    den_w   = {1'b0, ds_q[31:0]} + 33'(eps_r[31:8]);
    if (den_w == 33'd0) begin
      den_w = 33'd1;
    end
    r_w     = ds_stat.sat ? CAP40 : ds_q[39:0];
    if (mn_r[31]) begin
      nv_full = 52'(p_r) + $signed({2'b0, acc_sum});
    end else begin
      nv_full = 52'(p_r) - $signed({2'b0, acc_sum});
    end
    if (nv_full > 52'sd2147483647) begin
      nv_sat = 32'sh7FFF_FFFF;
    end else if (nv_full < -52'sd2147483648) begin
      nv_sat = -32'sh8000_0000;
    end else begin
      nv_sat = nv_full[31:0];
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_MOM: begin
        mul_a = 34'(m_old) - 34'(g_r);
        mul_b = {2'b0, b1_r};
      end
      ST_GSQ: begin
        mul_a = {2'b0, ag};
        mul_b = {2'b0, ag};
      end
      ST_VH: begin
        mul_a = {18'b0, v_old[47:32]};
        mul_b = {2'b0, b2_r};
      end
      ST_VL: begin
        mul_a = {2'b0, v_old[31:0]};
        mul_b = {2'b0, b2_r};
      end
      ST_GH: begin
        mul_a = {19'b0, g2_r[46:32]};
        mul_b = {1'b0, cb2};
      end
      ST_GL: begin
        mul_a = {2'b0, g2_r[31:0]};
        mul_b = {1'b0, cb2};
      end
      ST_P1: begin
        mul_a = {1'b0, bfp_r};
        mul_b = {2'b0, b1_r};
      end
      ST_P2: begin
        mul_a = {1'b0, bsp_r};
        mul_b = {2'b0, b2_r};
      end
      ST_WR: begin
        mul_a = {26'b0, r_w[39:32]};
        mul_b = {2'b0, rate_r};
      end
      ST_DL: begin
        mul_a = {2'b0, r_r[31:0]};
        mul_b = {2'b0, rate_r};
      end
      ST_R1: begin
        mul_a = {2'b0, decay_r};
        mul_b = {2'b0, step_r};
      end
      default: ;
    endcase
  end

  // divide / root unit launches
  always_comb begin
    ds_ctl = '0;
    ds_hi  = '0;
    ds_lo  = '0;
    ds_dsr = '0;
    case (state_r)
      ST_DMH: begin
        ds_ctl = '{start: 1'b1, sqrt_mode: 1'b0, iters: ITER_W'(40)};
        ds_hi  = 64'(mag[31:8]);
        ds_lo  = {mag[7:0], 56'b0};
        ds_dsr = 64'(c1);
      end
      ST_WMH: begin
        if (ds_stat.done) begin
          ds_ctl = '{start: 1'b1, sqrt_mode: 1'b0, iters: ITER_W'(48)};
          ds_hi  = 64'(vn_r[47:16]);
          ds_lo  = {vn_r[15:0], 48'b0};
          ds_dsr = 64'(c2);
        end
      end
      ST_WVH: begin
        if (ds_stat.done) begin
          ds_ctl = '{start: 1'b1, sqrt_mode: 1'b1, iters: ITER_W'(32)};
          ds_lo  = {vh_w, 16'b0};
        end
      end
      ST_WSQ: begin
        if (ds_stat.done) begin
          ds_ctl = '{start: 1'b1, sqrt_mode: 1'b0, iters: ITER_W'(40)};
          ds_hi  = 64'(mh_r[39:16]);
          ds_lo  = {mh_r[15:0], 48'b0};
          ds_dsr = 64'(den_w);
        end
      end
      ST_R2: begin
        // 2^32 + decay*step never overflows 64 bits
        ds_ctl = '{start: 1'b1, sqrt_mode: 1'b0, iters: ITER_W'(32)};
        ds_hi  = 64'(base_r);
        ds_dsr = prod_r[63:0] + 64'(ONE_Q32);
      end
      default: ;
    endcase
  end

  // moment memory write: clearing pass or item write-back
  always_comb begin
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else begin
      mem_we    = out_load & stored_r;
      mem_waddr = MEM_AW'(idx_r);
      mem_wdata = {mn_r, vn_r};
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == MEM_AW'(PARAM_COUNT - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (cfg_xfer && (cfg_ch.index == REG_BASE || cfg_ch.index == REG_DECAY)) begin
          state_nxt = ST_R1;
        end else if (in_xfer) begin
          state_nxt = ST_MOM;
        end
      end
      ST_MOM: state_nxt = ST_GSQ;
      ST_GSQ: state_nxt = ST_VH;
      ST_VH:  state_nxt = ST_VL;
      ST_VL:  state_nxt = ST_GH;
      ST_GH:  state_nxt = ST_GL;
      ST_GL:  state_nxt = ST_P1;
      ST_P1:  state_nxt = ST_P2;
      ST_P2:  state_nxt = ST_DMH;
      ST_DMH: state_nxt = ST_WMH;
      ST_WMH: if (ds_stat.done) state_nxt = ST_WVH;
      ST_WVH: if (ds_stat.done) state_nxt = ST_WSQ;
      ST_WSQ: if (ds_stat.done) state_nxt = ST_WR;
      ST_WR:  if (ds_stat.done) state_nxt = ST_DL;
      ST_DL:  state_nxt = ST_DS;
      ST_DS:  state_nxt = ST_WB;
      ST_WB: begin
        if (out_free) state_nxt = last_r ? ST_R1 : ST_IDLE;
      end
      ST_R1: state_nxt = ST_R2;
      ST_R2: state_nxt = ST_R3;
      ST_R3: if (ds_stat.done) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      base_r      <= BASE_RESET;
      decay_r     <= '0;
      eps_r       <= EPS_RESET;
      b1_r        <= B1_RESET;
      b2_r        <= B2_RESET;
      step_r      <= '0;
      rate_r      <= BASE_RESET;
      bfp_r       <= ONE_Q32;
      bsp_r       <= ONE_Q32;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_addr_r <= clr_addr_r + MEM_AW'(1);

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_xfer) begin
        unique case (cfg_ch.index)
          REG_BASE: begin
            base_r <= cfg_ch.data;
            // step count is still zero while clearing
            if (state_r == ST_CLEAR) rate_r <= cfg_ch.data;
          end
          REG_DECAY: decay_r <= cfg_ch.data;
          REG_EPS:   eps_r   <= cfg_ch.data;
          REG_B1:    b1_r    <= cfg_ch.data;
          REG_B2:    b2_r    <= cfg_ch.data;
          default: ;
        endcase
      end

      if (out_load && last_r) begin
        step_r <= step_r + 32'd1;
        bfp_r  <= p1_r;
        bsp_r  <= p2_r;
      end

      if (state_r == ST_R3 && ds_stat.done) rate_r <= ds_q[31:0];
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          idx_r    <= in_ch.param_index;
          g_r      <= in_ch.gradient;
          p_r      <= in_ch.param_value;
          last_r   <= in_ch.step_end;
          stored_r <= stored_in;
        end
      end
      ST_GSQ: mn_r  <= mom_sum[63:32];
      ST_VH:  g2_r  <= prod_r[62:16];
      ST_VL:  acc_r <= prod_r[49:0];
      ST_GH:  acc_r <= acc_sum;
      ST_GL:  acc_r <= acc_r + prod_r[49:0];
      ST_P1:  vn_r  <= acc_sum[47:0];
      ST_P2:  p1_r  <= prod_r[64:32];
      ST_DMH: p2_r  <= prod_r[64:32];
      ST_WMH: if (ds_stat.done) mh_r <= ds_stat.sat ? CAP40 : ds_q[39:0];
      ST_WR:  if (ds_stat.done) r_r <= r_w;
      ST_DL:  acc_r <= prod_r[49:0];
      ST_DS:  nv_r  <= nv_sat;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_index_r <= idx_r;
      new_value_r <= nv_r;
    end
  end

endmodule

// ===== design/apu_mult.sv =====
`timescale 1ns / 1ps

module apu_mult import apu_pkg::*; (
  input  logic               clk,
  input  logic signed [33:0] a,
  input  logic signed [33:0] b,
  output logic signed [67:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

endmodule

// ===== design/apu_divsqrt.sv =====
`timescale 1ns / 1ps

// Restoring divider / square root, one quotient or root bit per cycle.
// Divide: quotient of {hi, lo} / dsr with hi < dsr, else saturate at once.
// Root: floor(sqrt(lo)), two radicand bits per cycle.
module apu_divsqrt import apu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  ds_ctl_t     ctl,
  input  logic [63:0] hi,
  input  logic [63:0] lo,
  input  logic [63:0] dsr,
  output ds_stat_t    stat,
  output logic [47:0] q_r
);

  logic              run_r, done_r, sat_r, mode_r;
  logic [ITER_W-1:0] cnt_r;
  logic [65:0]       rem_r, rem_nxt;
  logic [63:0]       lo_r, dsr_r;
  logic [65:0]       div_sh, sq_sh, trial;
  logic              ge;

  always_comb begin
    div_sh = {rem_r[64:0], lo_r[63]};
    sq_sh  = {rem_r[63:0], lo_r[63:62]};
    trial  = {16'b0, q_r, 2'b01};
    if (mode_r) begin
      ge      = sq_sh >= trial;
      rem_nxt = ge ? sq_sh - trial : sq_sh;
    end else begin
      ge      = div_sh >= {2'b0, dsr_r};
      rem_nxt = ge ? div_sh - {2'b0, dsr_r} : div_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      sat_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        if (!ctl.sqrt_mode && hi >= dsr) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
          sat_r  <= 1'b1;
        end else begin
          run_r <= 1'b1;
          sat_r <= 1'b0;
        end
      end else if (run_r && cnt_r == ITER_W'(1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem_r  <= ctl.sqrt_mode ? 66'b0 : {2'b0, hi};
      lo_r   <= lo;
      q_r    <= '0;
      cnt_r  <= ctl.iters;
      mode_r <= ctl.sqrt_mode;
      dsr_r  <= dsr;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[46:0], ge};
      lo_r  <= mode_r ? {lo_r[61:0], 2'b0} : {lo_r[62:0], 1'b0};
      cnt_r <= cnt_r - ITER_W'(1);
    end
  end

  assign stat = '{done: done_r, sat: sat_r};

endmodule

// ===== design/apu_mem.sv =====
`timescale 1ns / 1ps

module apu_mem import apu_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [MEM_AW-1:0] waddr,
  input  logic [MEM_W-1:0]  wdata,
  input  logic              re,
  input  logic [MEM_AW-1:0] raddr,
  output logic [MEM_W-1:0]  rdata_r
);

  logic [MEM_W-1:0] mem_r [PARAM_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

// ===== design/apu_checker.sv =====
`timescale 1ns / 1ps

module apu_checker import apu_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [IDX_W-1:0]        out_index,
  input logic signed [VAL_W-1:0] new_value,
  input logic                    cfg_ready
);

  // one item at a time: busy right after a transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in flight");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result appeared right after input transfer");

  a_idle_takes_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> cfg_ready)
    else $error("item port ready while config port blocked");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(out_index) && $stable(new_value)))
    else $error("result payload changed while stalled");

endmodule

bind adam_parameter_update_top apu_checker u_apu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_index (out_ch.out_index),
  .new_value (out_ch.new_value),
  .cfg_ready (cfg_ch.ready)
);

// ===== bench/apu_bench_if.sv =====
`timescale 1ns / 1ps

// The channel interfaces (apu_in_if, apu_out_if, apu_cfg_if) are defined with
// the design and used here unchanged; this file only carries shared bench types.
package apu_bench_pkg;
  import apu_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value;
  } update_t;
endpackage

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import apu_pkg::*;
  import apu_bench_pkg::*;

  localparam logic [63:0] MASK48 = 64'hFFFF_FFFF_FFFF;
  localparam logic [63:0] CAP40Q = 64'hFF_FFFF_FFFF;
  localparam logic [63:0] ONEQ   = 64'h1_0000_0000;

  // Shadow of the optimizer state and registers; predicts one update per transfer.
  class adam_scoreboard;
    logic [31:0] base_rate, rate_decay, eps, b1, b2;
    logic signed [31:0] m_mem [PARAM_COUNT];
    logic [47:0] v_mem [PARAM_COUNT];
    logic [31:0] steps;
    logic [63:0] pow1, pow2;
    logic [31:0] cur_rate;
    update_t pending[$];
    int errors, checked;

    function new();
      base_rate = BASE_RESET; rate_decay = 0; eps = EPS_RESET;
      b1 = B1_RESET; b2 = B2_RESET;
      foreach (m_mem[i]) begin m_mem[i] = 0; v_mem[i] = 0; end
      steps = 0; pow1 = ONEQ; pow2 = ONEQ; cur_rate = base_rate;
      errors = 0; checked = 0;
    endfunction

    function logic [63:0] mulq(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[95:32];
    endfunction

    function logic [63:0] divq(logic [63:0] a, logic [63:0] b, int sh, logic [63:0] cap);
      logic [127:0] q;
      if (b == 0) b = 1;
      q = ({64'd0, a} << sh) / {64'd0, b};
      return (q > {64'd0, cap}) ? cap : q[63:0];
    endfunction

    function logic [63:0] root(logic [63:0] x);
      logic [63:0] r, bitv, rem;
      r = 0; bitv = 64'd1 << 62; rem = x;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
        if (rem >= r + bitv) begin rem -= r + bitv; r = (r >> 1) + bitv; end
        else r >>= 1;
        bitv >>= 2;
      end
      return r;
    endfunction

    function logic [31:0] decayed();
      logic [127:0] prod, den;
      if (steps == 0 || rate_decay == 0) return base_rate;
      prod = {96'd0, rate_decay} * {96'd0, steps};
      den = prod + {64'd0, ONEQ};
      if (den > 128'hFFFF_FFFF_FFFF_FFFF) den = 128'hFFFF_FFFF_FFFF_FFFF;
      return 32'(({96'd0, base_rate} << 32) / den);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
      case (idx)
        REG_BASE:  begin base_rate = d; cur_rate = decayed(); end
        REG_DECAY: begin rate_decay = d; cur_rate = decayed(); end
        REG_EPS:   eps = d;
        REG_B1:    b1 = d;
        REG_B2:    b2 = d;
        default: ;
      endcase
    endfunction

    function void note_input(logic [IDX_W-1:0] idx, logic signed [31:0] g,
                             logic signed [31:0] pv, logic last);
      logic signed [95:0] sum;
      logic signed [63:0] mn, nv;
      logic [63:0] ag, g2, vn, p1, p2, mag, mh, vh, s, den, r, d;
      update_t u;
      sum = 96'(m_mem[idx]) * $signed({64'd0, b1}) + 96'(g) * $signed({32'd0, ONEQ - b1});
      mn = 64'(sum >>> 32);
      ag = g < 0 ? 64'(-64'(g)) : 64'(g);
      g2 = (ag * ag) >> 16;
      vn = (mulq({16'd0, v_mem[idx]}, b2) + mulq(g2, ONEQ - b2)) & MASK48;
      p1 = mulq(pow1, b1);
      p2 = mulq(pow2, b2);
      mag = mn < 0 ? 64'(-mn) : 64'(mn);
      mh = divq(mag, ONEQ - p1, 32, CAP40Q);
      vh = divq(vn, ONEQ - p2, 32, MASK48);
      s = root(vh << 16);
      den = s + (eps >> 8);
      if (den == 0) den = 1;
      r = divq(mh, den, 24, CAP40Q);
      d = mulq(r, cur_rate);
      nv = mn < 0 ? 64'(pv) + $signed(d) : 64'(pv) - $signed(d);
      if (nv > 64'sd2147483647) nv = 64'sd2147483647;
      if (nv < -64'sd2147483648) nv = -64'sd2147483648;
      m_mem[idx] = 32'(mn);
      v_mem[idx] = vn[47:0];
      if (last) begin
        steps++; pow1 = p1; pow2 = p2; cur_rate = decayed();
      end
      u.index = idx; u.value = 32'(nv);
      pending.insert(pending.size(), u);
    endfunction

    function void check_result(logic [IDX_W-1:0] idx, logic signed [31:0] val);
      update_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result idx=%0d val=%0d", idx, val);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (e.index !== idx || e.value !== val) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected idx=%0d val=%0d, got idx=%0d val=%0d",
                   e.index, e.value, idx, val);
      end
    endfunction
  endclass

  logic clk, rst_n;
  apu_in_if  in_ch();
  apu_out_if out_ch();
  apu_cfg_if cfg_ch();
  adam_scoreboard sb;
  int in_idle_pct, out_idle_pct, sent, cfg_writes;

  adam_parameter_update_top i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg_ch(cfg_ch.sink)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("*** FAILED ***");
    $finish;
  end

  // monitors: sample at rising edge
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.out_index, out_ch.new_value);
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_input(in_ch.param_index, in_ch.gradient, in_ch.param_value, in_ch.step_end);
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // valid stays up after a transfer until the next item or an idle cycle;
  // the block is busy meanwhile, so it is not taken twice
  task automatic send_item(logic [IDX_W-1:0] idx, logic [31:0] g, logic [31:0] pv, logic last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 0;
      @(negedge clk);
    end
    in_ch.valid <= 1; in_ch.param_index <= idx; in_ch.gradient <= g;
    in_ch.param_value <= pv; in_ch.step_end <= last;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    sent++;
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
    cfg_ch.valid <= 1; cfg_ch.index <= idx; cfg_ch.data <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, d);
    @(negedge clk);
    cfg_ch.valid <= 0;
    cfg_writes++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (250) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(65535)) - 32768);
      3: return $urandom & 32'h03FF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_items(int n);
    int base;
    base = $urandom_range(PARAM_COUNT - 16);
    for (int k = 0; k < n; k++) begin
      // mostly a small working set so moments build up; sometimes anywhere
      send_item($urandom_range(9) == 0 ? IDX_W'($urandom) : IDX_W'(base + $urandom_range(15)),
                rand_word(), rand_word(), $urandom_range(7) == 0);
    end
  endtask

  initial begin
    sb = new();
    sent = 0; cfg_writes = 0;
    in_idle_pct = 17; out_idle_pct = 69;
    rst_n = 0;
    in_ch.valid = 0; in_ch.param_index = 0; in_ch.gradient = 0;
    in_ch.param_value = 0; in_ch.step_end = 0;
    cfg_ch.valid = 0; cfg_ch.index = 0; cfg_ch.data = 0;
    repeat (10) @(negedge clk);
    rst_n = 1;

    // directed: field extremes, zero gradient, step ends, index extremes
    send_item(0, 0, 0, 0);
    send_item(12'hFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    send_item(12'hFFF, 32'h8000_0000, 32'h8000_0000, 1);
    send_item(1, 32'h0100_0000, 32'h0, 1);
    send_item(1, 32'hFF00_0000, 32'h8000_0000, 0);
    send_item(2, 32'h1, 32'hFFFF_FFFF, 1);
    send_item(12'h555, 32'hAAAA_AAAA, 32'h5555_5555, 0);
    send_item(12'hAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1);
    drain();

    // extreme settings: zero epsilon/betas give a zero denominator, max rate
    write_cfg(REG_EPS, 0);
    write_cfg(REG_B1, 0);
    write_cfg(REG_B2, 0);
    write_cfg(REG_BASE, 32'hFFFF_FFFF);
    write_cfg(REG_DECAY, 32'hFFFF_FFFF);
    write_cfg(3'd7, 32'h1234_5678);  // unused register index
    send_item(100, 0, 32'h0100_0000, 0);
    send_item(100, 32'h7FFF_FFFF, 0, 1);
    send_item(101, 32'h8000_0000, 32'h7FFF_FFFF, 1);
    send_item(101, 32'h0000_0001, 32'h8000_0000, 0);
    drain();
    write_cfg(REG_B1, 32'hFFFF_FFFF);
    write_cfg(REG_B2, 32'hFFFF_FFFF);
    write_cfg(REG_EPS, 32'hFFFF_FFFF);
    send_item(200, 32'h7FFF_FFFF, 0, 1);
    send_item(200, 32'h8000_0000, 0, 1);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin in_idle_pct = 69; out_idle_pct = 17; end
      if (ph == 4) begin in_idle_pct = 0; out_idle_pct = 0; end
      if (ph % 2 == 0) begin
        write_cfg(REG_BASE, $urandom_range(1) ? $urandom : 32'd4294967);
        write_cfg(REG_DECAY, $urandom_range(1) ? 0 : $urandom >> $urandom_range(31));
        write_cfg(REG_EPS, $urandom_range(1) ? EPS_RESET : $urandom);
        write_cfg(REG_B1, $urandom_range(1) ? B1_RESET : $urandom);
        write_cfg(REG_B2, $urandom_range(1) ? B2_RESET : $urandom);
      end else begin
        write_cfg(REG_BASE, BASE_RESET);
        write_cfg(REG_DECAY, 32'd42949673);
        write_cfg(REG_EPS, EPS_RESET);
        write_cfg(REG_B1, B1_RESET);
        write_cfg(REG_B2, B2_RESET);
      end
      random_items(170);
      drain();
    end

    $display("Covered %0d parameter updates and %0d register writes over three", sent,
             cfg_writes);
    $display("handshake pressure profiles; %0d results compared.", sb.checked);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
